>>> sv/odet_pkg.sv
// odet_pkg: shared types and constants of the drum onset detector
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package odet_pkg;

  // ring memories, indexed by the low bits of the sample, centre and queue counters
  localparam int unsigned RING_AW = 13;
  localparam int unsigned RING_DEPTH = 1 << RING_AW;

  // window and look-ahead ceilings
  localparam logic [11:0] MAX_HALF_WINDOW = 12'd2048;
  localparam logic [10:0] MAX_LOOKAHEAD = 11'd1024;

  // input queue between front and back
  localparam int unsigned IN_FIFO_AW = 2;
  localparam int unsigned IN_FIFO_DEPTH = 1 << IN_FIFO_AW;

  localparam int unsigned CFG_ADDR_W = 5;

  // register indexes
  localparam logic [2:0] REG_ATTACK = 3'd0;
  localparam logic [2:0] REG_RELEASE = 3'd1;
  localparam logic [2:0] REG_HALF_WIN = 3'd2;
  localparam logic [2:0] REG_GAIN = 3'd3;
  localparam logic [2:0] REG_MIN_INT = 3'd4;
  localparam logic [2:0] REG_LOOKAHEAD = 3'd5;
  localparam logic [2:0] REG_STEREO = 3'd6;
  localparam logic [2:0] REG_NOTE = 3'd7;

  // register reset values
  localparam logic [15:0] RST_ATTACK = 16'd64184;
  localparam logic [15:0] RST_RELEASE = 16'd65508;
  localparam logic [11:0] RST_HALF_WIN = 12'd1024;
  localparam logic [17:0] RST_GAIN = 18'd32768;
  localparam logic [15:0] RST_MIN_INT = 16'd2400;
  localparam logic [10:0] RST_LOOKAHEAD = 11'd192;
  localparam logic RST_STEREO = 1'b1;
  localparam logic [6:0] RST_NOTE = 7'd36;

  // item kinds
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [15:0] attack_coeff;
    logic [15:0] release_coeff;
    logic [11:0] half_window_len;
    logic [17:0] sensitivity_gain;
    logic [15:0] min_interval_len;
    logic [10:0] lookahead_len;
    logic stereo_mode;
    logic [6:0] note_number;
  } cfg_t;

  typedef struct packed {
    logic op;
    logic [15:0] x;
  } item_t;

  typedef struct packed {
    logic hit_valid;
    logic [31:0] hit_index;
    logic [15:0] velocity;
    logic [6:0] hit_note;
    logic drained;
  } result_t;

  typedef enum logic [19:0] {
    S_IDLE      = 20'h00001,
    S_ENV1      = 20'h00002,
    S_ENV2      = 20'h00004,
    S_POPB      = 20'h00008,
    S_POPB_CMP  = 20'h00010,
    S_PUSH      = 20'h00020,
    S_CEN_CHK   = 20'h00040,
    S_HEAD_RD   = 20'h00080,
    S_HEAD_CMP  = 20'h00100,
    S_DEC_CHK   = 20'h00200,
    S_DEC_RD    = 20'h00400,
    S_DEC_CMP   = 20'h00800,
    S_WALK_RD   = 20'h01000,
    S_WALK_CMP  = 20'h02000,
    S_LP_RD     = 20'h04000,
    S_DIV_START = 20'h08000,
    S_DIV_WAIT  = 20'h10000,
    S_HIT_OUT   = 20'h20000,
    S_DEC_NEXT  = 20'h40000,
    S_DRAIN_OUT = 20'h80000
  } state_e;

endpackage
`default_nettype wire

>>> sv/odet_front.sv
// odet_front: rectifies the mono mix of each item and queues it for the back end
// depends on odet_pkg
`timescale 1ns / 1ps
`default_nettype none
module odet_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   op_i,
  input  logic [SAMPLE_BITS-1:0] left_i,
  input  logic [SAMPLE_BITS-1:0] right_i,
  input  logic                   stereo_i,
  output logic                   item_valid_o,
  input  logic                   item_ready_i,
  output odet_pkg::item_t        item_o
);
  import odet_pkg::*;

  logic signed [SAMPLE_BITS:0] mix;
  logic [SAMPLE_BITS:0] mag;
  logic [SAMPLE_BITS+16:0] scaled;
  item_t in_item;

  item_t fifo_q [IN_FIFO_DEPTH];
  logic [IN_FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [IN_FIFO_AW:0] cnt_q;
  logic push, pop;

  // mono mix, magnitude, scaled to q0.16 with saturation
  always_comb begin
    if (stereo_i) begin
      mix = $signed({left_i[SAMPLE_BITS-1], left_i}) + $signed({right_i[SAMPLE_BITS-1], right_i});
    end else begin
      mix = $signed({left_i, 1'b0});
    end
    mag = mix[SAMPLE_BITS] ? (~mix + 1'b1) : mix;
    scaled = {mag, 16'b0} >> SAMPLE_BITS;
    in_item.op = op_i;
    in_item.x = (|scaled[SAMPLE_BITS+16:16]) ? 16'hFFFF : scaled[15:0];
  end

  assign in_ready_o = (cnt_q != (IN_FIFO_AW+1)'(IN_FIFO_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o = fifo_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> sv/odet_div.sv
// odet_div: radix-2 restoring divider, 16-bit fraction of num/den with num < den
// depends on odet_pkg
`timescale 1ns / 1ps
`default_nettype none
module odet_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [15:0] quo_o
);
  import odet_pkg::*;

  logic busy_q, done_q;
  logic [4:0] cnt_q;
  logic [15:0] rem_q, den_q, quo_q;
  logic [16:0] rem2;
  logic take;

  assign rem2 = {rem_q, 1'b0};
  assign take = (rem2 >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? 16'(rem2 - {1'b0, den_q}) : rem2[15:0];
      quo_q <= {quo_q[14:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 5'd16;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o = quo_q;

endmodule
`default_nettype wire

>>> sv/odet_back.sv
// odet_back: envelope, sliding maximum, threshold decision, peak walk and result register
// depends on odet_pkg and odet_div
`timescale 1ns / 1ps
`default_nettype none
module odet_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  odet_pkg::cfg_t    cfg_i,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  odet_pkg::item_t   item_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output odet_pkg::result_t res_o
);
  import odet_pkg::*;

  state_e state_q, state_d;

  logic drain_q, drain_d;
  logic [15:0] x_q, x_d;
  logic atk_q, atk_d;
  logic [31:0] prod_q, prod_d;
  logic [15:0] lev_q, lev_d;
  logic [31:0] count_q, count_d, centre_q, centre_d, dec_q, dec_d, last_hit_q, last_hit_d;
  logic hit_seen_q, hit_seen_d, above_q, above_d;
  logic [RING_AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [11:0] h_q, h_d;
  logic [10:0] l_q, l_d;
  logic [15:0] peak_q, peak_d;
  logic [RING_AW-1:0] pidx_q, pidx_d;
  logic [10:0] j_q, j_d, span_q, span_d;
  logic [15:0] vel_q, vel_d;
  logic out_valid_q, out_valid_d;
  result_t out_q, out_d;

  // ring memories
  logic [15:0] env_mem [RING_DEPTH];
  logic [15:0] lm_mem [RING_DEPTH];
  logic [31:0] cq_mem [RING_DEPTH];
  logic [15:0] env_rd_q, lm_rd_q;
  logic [31:0] cq_rd_q;
  logic env_we, lm_we, cq_we;
  logic [RING_AW-1:0] env_ra, lm_ra, cq_ra, walk_addr;
  logic [15:0] lm_wd;

  // datapath terms
  logic [15:0] coef;
  logic [16:0] atk_inv;
  logic [32:0] add_term;
  logic [33:0] env_sum;
  logic [15:0] lev_new;
  logic [31:0] cnt_minus_dec, cnt_minus_cen, since_hit;
  logic [12:0] delay;
  logic [15:0] lo16, head_diff;
  logic [33:0] thr, env_sh;
  logic over, gated;
  logic [10:0] span_new;
  logic [19:0] ten_v, nine_p;
  logic out_free;
  logic div_start, div_done;
  logic [15:0] div_quo;

  odet_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (peak_q),
    .den_i   (lm_rd_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign walk_addr = dec_q[RING_AW-1:0] + RING_AW'(j_q);
  assign env_ra = (state_q == S_DEC_RD) ? dec_q[RING_AW-1:0] : walk_addr;
  assign lm_ra = (state_q == S_LP_RD) ? pidx_q : dec_q[RING_AW-1:0];
  assign cq_ra = (state_q == S_POPB) ? (tail_q - 1'b1) : head_q;
  assign env_we = (state_q == S_ENV2);
  assign cq_we = (state_q == S_PUSH);

  always_ff @(posedge clk_i) begin
    if (env_we) env_mem[count_q[RING_AW-1:0]] <= lev_new;
    env_rd_q <= env_mem[env_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lm_we) lm_mem[centre_q[RING_AW-1:0]] <= lm_wd;
    lm_rd_q <= lm_mem[lm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cq_we) cq_mem[tail_q] <= {count_q[15:0], lev_q};
    cq_rd_q <= cq_mem[cq_ra];
  end

  always_comb begin
    coef = atk_d ? cfg_i.attack_coeff : cfg_i.release_coeff;
    atk_inv = 17'h10000 - {1'b0, cfg_i.attack_coeff};
    add_term = atk_q ? (33'(atk_inv) * 33'(x_q)) : 33'd0;
    env_sum = {2'b0, prod_q} + {1'b0, add_term};
    lev_new = env_sum[31:16];
    cnt_minus_dec = count_q - dec_q;
    cnt_minus_cen = count_q - centre_q;
    since_hit = dec_q - last_hit_q;
    delay = {1'b0, h_q} + ((l_q != '0) ? (13'(l_q) - 13'd1) : 13'd0);
    lo16 = centre_q[15:0] - {4'b0, h_q};
    head_diff = cq_rd_q[31:16] - lo16;
    thr = 34'(lm_rd_q) * 34'(cfg_i.sensitivity_gain);
    env_sh = {2'b0, env_rd_q, 16'b0};
    over = (env_sh > thr);
    gated = hit_seen_q && (since_hit < {16'b0, cfg_i.min_interval_len});
    span_new = (cnt_minus_dec < {21'b0, l_q}) ? cnt_minus_dec[10:0] : l_q;
    ten_v = {1'b0, env_rd_q, 3'b0} + {3'b0, env_rd_q, 1'b0};
    nine_p = {1'b0, peak_q, 3'b0} + {4'b0, peak_q};
    out_free = !out_valid_q || res_ready_i;
  end

  always_comb begin
    state_d = state_q;
    drain_d = drain_q;
    x_d = x_q;
    atk_d = atk_q;
    prod_d = prod_q;
    lev_d = lev_q;
    count_d = count_q;
    centre_d = centre_q;
    dec_d = dec_q;
    last_hit_d = last_hit_q;
    hit_seen_d = hit_seen_q;
    above_d = above_q;
    head_d = head_q;
    tail_d = tail_q;
    h_d = h_q;
    l_d = l_q;
    peak_d = peak_q;
    pidx_d = pidx_q;
    j_d = j_q;
    span_d = span_q;
    vel_d = vel_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d = out_q;
    lm_we = 1'b0;
    lm_wd = cq_rd_q[15:0];
    div_start = 1'b0;
    item_ready_o = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          drain_d = (item_i.op == OP_DRAIN);
          x_d = item_i.x;
          if (item_i.op == OP_DRAIN) begin
            state_d = S_CEN_CHK;
          end else begin
            if (count_q == '0) begin
              h_d = (cfg_i.half_window_len > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW
                                                              : cfg_i.half_window_len;
              l_d = (cfg_i.lookahead_len > MAX_LOOKAHEAD) ? MAX_LOOKAHEAD
                                                          : cfg_i.lookahead_len;
            end
            state_d = S_ENV1;
          end
        end
      end
      S_ENV1: begin
        atk_d = (x_q > lev_q);
        prod_d = 32'(coef) * 32'(lev_q);
        state_d = S_ENV2;
      end
      S_ENV2: begin
        lev_d = lev_new;
        state_d = S_POPB;
      end
      S_POPB: begin
        state_d = (tail_q != head_q) ? S_POPB_CMP : S_PUSH;
      end
      S_POPB_CMP: begin
        if (cq_rd_q[15:0] <= lev_q) begin
          tail_d = tail_q - 1'b1;
          state_d = S_POPB;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        tail_d = tail_q + 1'b1;
        count_d = count_q + 1'b1;
        state_d = S_CEN_CHK;
      end
      S_CEN_CHK: begin
        if (drain_q ? (centre_q != count_q) : (cnt_minus_cen > {20'b0, h_q})) begin
          state_d = S_HEAD_RD;
        end else begin
          state_d = S_DEC_CHK;
        end
      end
      S_HEAD_RD: begin
        if (head_q == tail_q) begin
          // empty window: local maximum is zero
          lm_we = 1'b1;
          lm_wd = '0;
          centre_d = centre_q + 1'b1;
          state_d = S_CEN_CHK;
        end else begin
          state_d = S_HEAD_CMP;
        end
      end
      S_HEAD_CMP: begin
        if (head_diff[15]) begin
          head_d = head_q + 1'b1;
          state_d = S_HEAD_RD;
        end else begin
          lm_we = 1'b1;
          centre_d = centre_q + 1'b1;
          state_d = S_CEN_CHK;
        end
      end
      S_DEC_CHK: begin
        if (drain_q ? (dec_q != count_q) : (cnt_minus_dec > {19'b0, delay})) begin
          state_d = S_DEC_RD;
        end else begin
          state_d = drain_q ? S_DRAIN_OUT : S_IDLE;
        end
      end
      S_DEC_RD: begin
        state_d = S_DEC_CMP;
      end
      S_DEC_CMP: begin
        if (!above_q && over) begin
          above_d = 1'b1;
          if (gated) begin
            state_d = S_DEC_NEXT;
          end else begin
            peak_d = env_rd_q;
            pidx_d = dec_q[RING_AW-1:0];
            j_d = 11'd1;
            span_d = span_new;
            state_d = S_WALK_RD;
          end
        end else begin
          if (above_q && !over) above_d = 1'b0;
          state_d = S_DEC_NEXT;
        end
      end
      S_WALK_RD: begin
        state_d = (j_q < span_q) ? S_WALK_CMP : S_LP_RD;
      end
      S_WALK_CMP: begin
        if (env_rd_q > peak_q) begin
          peak_d = env_rd_q;
          pidx_d = walk_addr;
          j_d = j_q + 1'b1;
          state_d = S_WALK_RD;
        end else if (ten_v < nine_p) begin
          state_d = S_LP_RD;
        end else begin
          j_d = j_q + 1'b1;
          state_d = S_WALK_RD;
        end
      end
      S_LP_RD: begin
        state_d = S_DIV_START;
      end
      S_DIV_START: begin
        if (lm_rd_q == '0) begin
          vel_d = '0;
          state_d = S_HIT_OUT;
        end else if (peak_q >= lm_rd_q) begin
          vel_d = 16'hFFFF;
          state_d = S_HIT_OUT;
        end else begin
          div_start = 1'b1;
          state_d = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          vel_d = div_quo;
          state_d = S_HIT_OUT;
        end
      end
      S_HIT_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.hit_valid = 1'b1;
          out_d.hit_index = dec_q;
          out_d.velocity = vel_q;
          out_d.hit_note = cfg_i.note_number;
          out_d.drained = 1'b0;
          hit_seen_d = 1'b1;
          last_hit_d = dec_q;
          state_d = S_DEC_NEXT;
        end
      end
      S_DEC_NEXT: begin
        dec_d = dec_q + 1'b1;
        state_d = (drain_q && (dec_d == count_q)) ? S_DRAIN_OUT : S_IDLE;
      end
      S_DRAIN_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '0;
          out_d.drained = 1'b1;
          // clip restart, registers kept
          lev_d = '0;
          count_d = '0;
          centre_d = '0;
          dec_d = '0;
          last_hit_d = '0;
          hit_seen_d = 1'b0;
          above_d = 1'b0;
          head_d = '0;
          tail_d = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    drain_q <= drain_d;
    x_q <= x_d;
    atk_q <= atk_d;
    prod_q <= prod_d;
    peak_q <= peak_d;
    pidx_q <= pidx_d;
    j_q <= j_d;
    span_q <= span_d;
    vel_q <= vel_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lev_q <= '0;
      count_q <= '0;
      centre_q <= '0;
      dec_q <= '0;
      last_hit_q <= '0;
      hit_seen_q <= 1'b0;
      above_q <= 1'b0;
      head_q <= '0;
      tail_q <= '0;
      h_q <= RST_HALF_WIN;
      l_q <= RST_LOOKAHEAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lev_q <= lev_d;
      count_q <= count_d;
      centre_q <= centre_d;
      dec_q <= dec_d;
      last_hit_q <= last_hit_d;
      hit_seen_q <= hit_seen_d;
      above_q <= above_d;
      head_q <= head_d;
      tail_q <= tail_d;
      h_q <= h_d;
      l_q <= l_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o = out_q;

endmodule
`default_nettype wire

>>> sv/drum_onset_detector_core.sv
// drum_onset_detector_core: top level, apb register file, front queue and back engine
// depends on odet_pkg, odet_front, odet_back (odet_div below it)
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata {right, left}, tuser op
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata {note, vel, index}, tuser hit, tlast drained
// apb       in   psel/penable/pwrite, pready=1   8 registers at 4*i, read back on prdata
//
// in the back engine a sample item updates the envelope, drops candidates from the back of the max
// queue, pushes itself, ages candidates out of the front and, once the window is full, makes one
// threshold decision; a hit adds the look-ahead walk, a peak fetch and the 16-step divider (skipped
// when the local maximum is zero or not above the peak). one sequencer runs all of this in turn.
// reset clears all control state; ring memories have no clearing pass and are written before
// use. the 4-entry input queue takes transfers while the engine works; a full result register
// stalls the engine until m_axis takes it
`timescale 1ns / 1ps
`default_nettype none
module drum_onset_detector_core #(
  parameter int unsigned SAMPLE_BITS = 16,
  localparam int unsigned InDataW = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [InDataW-1:0]            s_axis_tdata_i,  // left_sample, right_sample
  input  logic                          s_axis_tuser_i,  // op
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [55:0]                   m_axis_tdata_o,  // hit_index, velocity, hit_note
  output logic                          m_axis_tuser_o,  // hit_valid
  output logic                          m_axis_tlast_o,  // drained
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [odet_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import odet_pkg::*;

  cfg_t cfg_q;
  logic cfg_wr;
  logic [2:0] reg_idx;

  logic item_valid, item_ready;
  item_t item;
  logic res_valid;
  result_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // register file, writes land on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coeff <= RST_ATTACK;
      cfg_q.release_coeff <= RST_RELEASE;
      cfg_q.half_window_len <= RST_HALF_WIN;
      cfg_q.sensitivity_gain <= RST_GAIN;
      cfg_q.min_interval_len <= RST_MIN_INT;
      cfg_q.lookahead_len <= RST_LOOKAHEAD;
      cfg_q.stereo_mode <= RST_STEREO;
      cfg_q.note_number <= RST_NOTE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ATTACK:    cfg_q.attack_coeff <= pwdata[15:0];
        REG_RELEASE:   cfg_q.release_coeff <= pwdata[15:0];
        REG_HALF_WIN:  cfg_q.half_window_len <= pwdata[11:0];
        REG_GAIN:      cfg_q.sensitivity_gain <= pwdata[17:0];
        REG_MIN_INT:   cfg_q.min_interval_len <= pwdata[15:0];
        REG_LOOKAHEAD: cfg_q.lookahead_len <= pwdata[10:0];
        REG_STEREO:    cfg_q.stereo_mode <= pwdata[0];
        REG_NOTE:      cfg_q.note_number <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_ATTACK:    prdata = {16'b0, cfg_q.attack_coeff};
      REG_RELEASE:   prdata = {16'b0, cfg_q.release_coeff};
      REG_HALF_WIN:  prdata = {20'b0, cfg_q.half_window_len};
      REG_GAIN:      prdata = {14'b0, cfg_q.sensitivity_gain};
      REG_MIN_INT:   prdata = {16'b0, cfg_q.min_interval_len};
      REG_LOOKAHEAD: prdata = {21'b0, cfg_q.lookahead_len};
      REG_STEREO:    prdata = {31'b0, cfg_q.stereo_mode};
      REG_NOTE:      prdata = {25'b0, cfg_q.note_number};
      default:       prdata = '0;
    endcase
  end

  // front: rectify and queue
  odet_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .op_i         (s_axis_tuser_i),
    .left_i       (s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .right_i      (s_axis_tdata_i[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .stereo_i     (cfg_q.stereo_mode),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // back: envelope, window max, decisions, result register
  odet_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (res)
  );

  assign m_axis_tvalid_o = res_valid;
  assign m_axis_tdata_o = {1'b0, res.hit_note, res.velocity, res.hit_index};
  assign m_axis_tuser_o = res.hit_valid;
  assign m_axis_tlast_o = res.drained;

endmodule
`default_nettype wire

>>> sim/drum_onset_detector_core_test.sv
// drum_onset_detector_core_test: self-checking bench for the drum onset detector
// depends on odet_pkg and drum_onset_detector_core; predicts every result in-bench
`timescale 1ns / 1ps
`default_nettype none
module drum_onset_detector_core_test;
  import odet_pkg::*;

  localparam int unsigned RING = 8192;
  localparam int unsigned WDOG_LIMIT = 200000;
  localparam int unsigned EXP_DEPTH = 256;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;  // left_sample, right_sample
  logic s_axis_tuser_i = 1'b0;       // op
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;       // hit_index, velocity, hit_note
  logic m_axis_tuser_o;              // hit_valid
  logic m_axis_tlast_o;              // drained
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  drum_onset_detector_core uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0] cf_attack, cf_release, cf_minint;
  logic [11:0] cf_halfwin;
  logic [17:0] cf_gain;
  logic [10:0] cf_look;
  logic cf_stereo;
  logic [6:0] cf_note;

  logic [15:0] env_level;
  logic [15:0] env_ring[RING];
  logic [15:0] lmax_ring[RING];
  logic [31:0] cand_q[RING];
  logic [31:0] q_head, q_tail, centre_next, in_count, dec_idx, last_hit;
  logic above, hit_seen;
  logic [31:0] h_act, l_act;

  // expected results, in order
  result_t exp_mem[EXP_DEPTH];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int errors = 0;
  int stall_pct = 0;
  int gap_pct = 0;

  function automatic int unsigned slot(logic [31:0] i);
    return i % RING;
  endfunction

  function automatic void queue_result(result_t r);
    exp_mem[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  function automatic void clip_restart();
    env_level = '0; in_count = '0; dec_idx = '0; above = 1'b0; hit_seen = 1'b0;
    last_hit = '0; q_head = '0; q_tail = '0; centre_next = '0;
  endfunction

  function automatic void close_window(logic [31:0] c);
    logic [31:0] lo, f;
    lo = c - h_act;
    while (q_tail != q_head) begin
      f = cand_q[slot(q_head)];
      if (((f - lo) & 32'h8000_0000) == 0) break;
      q_head++;
    end
    lmax_ring[slot(c)] = (q_tail != q_head) ? env_ring[slot(cand_q[slot(q_head)])] : 16'd0;
    centre_next = c + 1;
  endfunction

  // threshold decision at one position; queues a hit when one is reported
  function automatic void decide_onset(logic [31:0] d, logic [31:0] stop);
    logic [63:0] e, lm, peak, v, lp, vel;
    logic [31:0] span, pidx;
    logic over;
    result_t r;
    e = env_ring[slot(d)];
    lm = lmax_ring[slot(d)];
    over = (e << 16) > lm * cf_gain;
    if (!above && over) begin
      above = 1'b1;
      if (hit_seen && (d - last_hit) < cf_minint) return;
      span = l_act;
      if ((stop - d) < span) span = stop - d;
      peak = e; pidx = d; vel = 0;
      for (int unsigned j = 1; j < span; j++) begin
        v = env_ring[slot(d + j)];
        if (v > peak) begin
          peak = v; pidx = d + j;
        end else if (10 * v < 9 * peak) break;
      end
      lp = lmax_ring[slot(pidx)];
      if (lp != 0) begin
        vel = (peak << 16) / lp;
        if (vel > 65535) vel = 65535;
      end
      r = '{hit_valid: 1'b1, hit_index: d, velocity: vel[15:0], hit_note: cf_note,
            drained: 1'b0};
      queue_result(r);
      hit_seen = 1'b1;
      last_hit = d;
      return;
    end
    if (above && !over) above = 1'b0;
  endfunction

  function automatic void predict_item(logic op, logic signed [15:0] l,
                                       logic signed [15:0] r);
    logic signed [17:0] s;
    logic [63:0] x, lev;
    logic [31:0] i, delay;
    result_t dr;
    if (op == OP_SAMPLE) begin
      i = in_count;
      if (in_count == 0) begin
        h_act = (cf_halfwin > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : cf_halfwin;
        l_act = (cf_look > MAX_LOOKAHEAD) ? MAX_LOOKAHEAD : cf_look;
      end
      s = cf_stereo ? (18'(l) + 18'(r)) : 18'(18'(l) * 2);
      if (s < 0) s = -s;
      x = 64'(s);
      if (x > 65535) x = 65535;
      lev = env_level;
      if (x > lev) lev = (cf_attack * lev + (65536 - cf_attack) * x) >> 16;
      else lev = (cf_release * lev) >> 16;
      env_level = lev[15:0];
      env_ring[slot(i)] = env_level;
      while (q_tail != q_head && env_ring[slot(cand_q[slot(q_tail - 1)])] <= env_level)
        q_tail--;
      cand_q[slot(q_tail)] = i;
      q_tail++;
      in_count = i + 1;
      while ((in_count - centre_next) > h_act) close_window(centre_next);
      delay = h_act + ((l_act != 0) ? l_act - 1 : 0);
      if ((in_count - dec_idx) > delay) begin
        decide_onset(dec_idx, in_count);
        dec_idx++;
      end
    end else begin
      while (centre_next != in_count) close_window(centre_next);
      if (dec_idx != in_count) begin
        decide_onset(dec_idx, in_count);
        dec_idx++;
      end
      if (dec_idx == in_count) begin
        dr = '0;
        dr.drained = 1'b1;
        queue_result(dr);
        clip_restart();
      end
    end
  endfunction

  // register write: setup then access, mirrored into the predictor
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ATTACK:    cf_attack = val[15:0];
      REG_RELEASE:   cf_release = val[15:0];
      REG_HALF_WIN:  cf_halfwin = val[11:0];
      REG_GAIN:      cf_gain = val[17:0];
      REG_MIN_INT:   cf_minint = val[15:0];
      REG_LOOKAHEAD: cf_look = val[10:0];
      REG_STEREO:    cf_stereo = val[0];
      REG_NOTE:      cf_note = val[6:0];
      default: ;
    endcase
  endtask

  // one input transfer; the sender may idle first, tvalid stays up between items
  task automatic send_item(logic op, logic [15:0] l, logic [15:0] r);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {r, l};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_item(op, l, r);
  endtask

  // wait for every queued result, then a quiet spell before any register write
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
  endtask

  task automatic drain_clip();
    do begin
      send_item(OP_DRAIN, 16'($urandom), 16'($urandom));
    end while (in_count != 0 || dec_idx != 0);
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    result_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (exp_wr == exp_rd) begin
        $error("result with nothing expected: idx %0d", m_axis_tdata_o[31:0]);
        errors++;
      end else begin
        want = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (m_axis_tuser_o !== want.hit_valid) begin
          $error("hit_valid exp %0d got %0d", want.hit_valid, m_axis_tuser_o); errors++;
        end
        if (m_axis_tdata_o[31:0] !== want.hit_index) begin
          $error("hit_index exp %0d got %0d", want.hit_index, m_axis_tdata_o[31:0]);
          errors++;
        end
        if (m_axis_tdata_o[47:32] !== want.velocity) begin
          $error("velocity exp %0d got %0d", want.velocity, m_axis_tdata_o[47:32]);
          errors++;
        end
        if (m_axis_tdata_o[54:48] !== want.hit_note) begin
          $error("hit_note exp %0d got %0d", want.hit_note, m_axis_tdata_o[54:48]);
          errors++;
        end
        if (m_axis_tlast_o !== want.drained) begin
          $error("drained exp %0d got %0d", want.drained, m_axis_tlast_o); errors++;
        end
      end
    end
    if (rst_ni) m_axis_tready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles without any transfer
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WDOG_LIMIT) begin
      $display("drum_onset_detector_core verification failed");
      $finish;
    end
  end

  // a burst of loud samples then decay; a typical drum hit
  task automatic hit_burst(int unsigned quiet_len, int unsigned loud_len);
    logic [15:0] a;
    repeat (loud_len) begin
      a = 16'($urandom);
      send_item(OP_SAMPLE, a, $urandom_range(1) ? a : 16'($urandom));
    end
    repeat (quiet_len)
      send_item(OP_SAMPLE, 16'($urandom_range(255)), 16'($urandom_range(255)));
  endtask

  task automatic test_register_readback();
    write_reg(REG_NOTE, 32'd127);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b0; paddr <= CFG_ADDR_W'(REG_NOTE) << 2;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[6:0] !== 7'd127) begin
      $error("note_number exp %0d got %0d", 127, prdata[6:0]); errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // field extremes, mono/stereo, empty drain, zero window and look-ahead
  task automatic test_directed();
    write_reg(REG_HALF_WIN, 32'd2); write_reg(REG_LOOKAHEAD, 32'd3);
    write_reg(REG_MIN_INT, 32'd1); write_reg(REG_GAIN, 32'd32768);
    send_item(OP_DRAIN, 16'hffff, 16'hffff);  // empty clip
    send_item(OP_SAMPLE, 16'h8000, 16'h8000);
    send_item(OP_SAMPLE, 16'h7fff, 16'h7fff);
    send_item(OP_SAMPLE, 16'h0000, 16'h0000);
    send_item(OP_SAMPLE, 16'h7fff, 16'h8000);
    send_item(OP_SAMPLE, 16'hffff, 16'h0001);
    send_item(OP_SAMPLE, 16'h8000, 16'h0000);
    drain_clip();
    settle();
    write_reg(REG_STEREO, 32'd0); write_reg(REG_HALF_WIN, 32'd0);
    write_reg(REG_LOOKAHEAD, 32'd0); write_reg(REG_GAIN, 32'd0);
    send_item(OP_SAMPLE, 16'h8000, 16'h1234);
    send_item(OP_SAMPLE, 16'h0000, 16'hffff);
    send_item(OP_SAMPLE, 16'h7fff, 16'h0000);
    send_item(OP_SAMPLE, 16'h0000, 16'h0000);
    drain_clip();
    settle();
  endtask

  // random clips under one register setting
  task automatic run_clips(int unsigned items);
    int unsigned sent, ql, ll;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        send_item(OP_SAMPLE, 16'($urandom), 16'($urandom)); sent++;
      end else begin
        ql = $urandom_range(20, 4);
        ll = $urandom_range(3, 1);
        hit_burst(ql, ll);
        sent += ql + ll;
      end
      if ($urandom_range(15) == 0) drain_clip();
    end
    drain_clip();
    settle();
  endtask

  task automatic set_random_config(logic extreme);
    write_reg(REG_ATTACK, extreme ? 32'd0 : $urandom_range(65535, 30000));
    write_reg(REG_RELEASE, extreme ? 32'd65535 : $urandom_range(65535, 40000));
    write_reg(REG_HALF_WIN, extreme ? 32'd4095 : $urandom_range(12));
    write_reg(REG_GAIN, extreme ? 32'h3ffff : $urandom_range(60000, 8000));
    write_reg(REG_MIN_INT, extreme ? 32'd65535 : $urandom_range(8, 0));
    write_reg(REG_LOOKAHEAD, extreme ? 32'd2047 : $urandom_range(8));
    write_reg(REG_STEREO, $urandom_range(1));
    write_reg(REG_NOTE, $urandom_range(127));
  endtask

  task automatic test_random();
    int pcts[4][2] = '{'{0, 0}, '{78, 0}, '{0, 78}, '{37, 37}};
    for (int p = 0; p < 4; p++) begin
      gap_pct = pcts[p][0]; stall_pct = pcts[p][1];
      set_random_config(1'b0);
      run_clips(160);
    end
    gap_pct = 0; stall_pct = 0;
    set_random_config(1'b1);
    run_clips(60);
    write_reg(REG_HALF_WIN, 32'd2048); write_reg(REG_LOOKAHEAD, 32'd1024);
    write_reg(REG_MIN_INT, 32'd0); write_reg(REG_GAIN, 32'd1);
    run_clips(40);
  endtask

  initial begin
    cf_attack = RST_ATTACK; cf_release = RST_RELEASE; cf_halfwin = RST_HALF_WIN;
    cf_gain = RST_GAIN; cf_minint = RST_MIN_INT; cf_look = RST_LOOKAHEAD;
    cf_stereo = RST_STEREO; cf_note = RST_NOTE;
    h_act = RST_HALF_WIN; l_act = RST_LOOKAHEAD;
    clip_restart();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_readback();
    test_directed();
    test_random();
    if (errors == 0) begin
      $display("drum_onset_detector_core verification clean");
    end else begin
      $display("drum_onset_detector_core verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
sv/odet_pkg.sv
sv/odet_front.sv
sv/odet_div.sv
sv/odet_back.sv
sv/drum_onset_detector_core.sv
sim/drum_onset_detector_core_test.sv
